// ===== hdl/polynomial_xor_string_hash_core_macros.svh =====
// assertion macros shared by the string hash checker
// no dependencies; included by files that hold concurrent assertions
`ifndef POLYNOMIAL_XOR_STRING_HASH_CORE_MACROS_SVH
`define POLYNOMIAL_XOR_STRING_HASH_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PXSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pxsh: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PXSH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pxsh: next-cycle check failed");

`endif

// ===== hdl/pxsh_pkg.sv =====
// widths and constants of the polynomial xor string hash
// no dependencies; compiled before every other file of the block
`default_nettype none

package pxsh_pkg;

	localparam int CHAR_W  = 8;
	localparam int HASH_W  = 64;
	localparam int TABLE_W = 32;

	localparam logic [HASH_W-1:0]  HASH_PRIME     = 64'd1028201;
	localparam logic [HASH_W-1:0]  HASH_MASK      = 64'h0000_0000_D32D_E03A;
	localparam logic [HASH_W-1:0]  HASH_RST       = 64'd0;
	localparam logic [HASH_W-1:0]  POWER_RST      = 64'd1;
	localparam logic [TABLE_W-1:0] TABLE_SIZE_RST = 32'd1024;

endpackage

`default_nettype wire

// ===== hdl/pxsh_ifs.sv =====
// valid/ready channel interfaces: string bytes in, bucket index out, table size config
// depends on pxsh_pkg for field widths
`default_nettype none

interface pxsh_char_if;
	import pxsh_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_byte;
	logic              last_char;
	modport source (output valid, char_byte, last_char, input ready);
	modport sink (input valid, char_byte, last_char, output ready);
endinterface

interface pxsh_bucket_if;
	import pxsh_pkg::*;
	logic               valid;
	logic               ready;
	logic [TABLE_W-1:0] bucket_index;
	modport source (output valid, bucket_index, input ready);
	modport sink (input valid, bucket_index, output ready);
endinterface

interface pxsh_cfg_if;
	import pxsh_pkg::*;
	logic               valid;
	logic               ready;
	logic [TABLE_W-1:0] table_size;
	modport source (output valid, table_size, input ready);
	modport sink (input valid, table_size, output ready);
endinterface

`default_nettype wire

// ===== hdl/polynomial_xor_string_hash_core.sv =====
// polynomial xor string hash core: one string byte per beat, bucket index per string
// each byte makes two passes through the shared 32x32 multiplier, byte times power
// and then power times prime, each in steps LL, LH, HL and SUM; ready is low meanwhile
// the final byte then passes through the one-bit-a-cycle remainder unit, which waits
// to start while a previous index has not yet been taken
// arst_n clears hash to 0, power to 1, table_size to 1024 and drops all valids
`default_nettype none

module polynomial_xor_string_hash_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pxsh_char_if.sink     chars,
	pxsh_bucket_if.source buckets,
	pxsh_cfg_if.sink      cfg
);
	import pxsh_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_PROD_GO   = 7'b0000010,
		ST_PROD_WAIT = 7'b0000100,
		ST_POW_GO    = 7'b0001000,
		ST_POW_WAIT  = 7'b0010000,
		ST_DIV_GO    = 7'b0100000,
		ST_DIV_WAIT  = 7'b1000000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [CHAR_W-1:0]  byte_q;
	logic               last_q;
	logic [HASH_W-1:0]  hash_q;
	logic [HASH_W-1:0]  power_q;
	logic [TABLE_W-1:0] table_size_q;
	logic [TABLE_W-1:0] result_q;
	logic               out_vld_q;
	logic               in_beat;
	logic               pow_phase;
	logic               mul_start;
	logic               mul_done;
	logic [HASH_W-1:0]  mul_a;
	logic [HASH_W-1:0]  mul_b;
	logic [HASH_W-1:0]  mul_p;
	logic               div_start;
	logic               div_done;
	logic [TABLE_W-1:0] div_rem;

	assign in_beat = chars.valid && chars.ready;

	// shared multiplier: byte times power, then power times prime
	assign pow_phase = (state_q == ST_POW_GO) || (state_q == ST_POW_WAIT);
	assign mul_start = (state_q == ST_PROD_GO) || (state_q == ST_POW_GO);
	assign mul_a     = pow_phase ? power_q : {{(HASH_W-CHAR_W){byte_q[CHAR_W-1]}}, byte_q};
	assign mul_b     = pow_phase ? HASH_PRIME : power_q;

	pxsh_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	// remainder unit starts only once the previous index has been taken
	assign div_start = (state_q == ST_DIV_GO) && !out_vld_q;

	pxsh_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (hash_q),
		.divisor   (table_size_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_beat) state_d = ST_PROD_GO;
			ST_PROD_GO:   state_d = ST_PROD_WAIT;
			ST_PROD_WAIT: if (mul_done) state_d = ST_POW_GO;
			ST_POW_GO:    state_d = ST_POW_WAIT;
			ST_POW_WAIT: begin
				if (mul_done) state_d = last_q ? ST_DIV_GO : ST_IDLE;
			end
			ST_DIV_GO:    if (!out_vld_q) state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (div_done) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hash state, table size and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q       <= HASH_RST;
			power_q      <= POWER_RST;
			table_size_q <= TABLE_SIZE_RST;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				table_size_q <= cfg.table_size;
			end
			if (buckets.valid && buckets.ready) begin
				out_vld_q <= 1'b0;
			end
			if ((state_q == ST_PROD_WAIT) && mul_done) begin
				hash_q <= (hash_q + mul_p) ^ HASH_MASK;
			end
			if ((state_q == ST_POW_WAIT) && mul_done) begin
				power_q <= mul_p;
			end
			if ((state_q == ST_DIV_WAIT) && div_done) begin
				hash_q    <= HASH_RST;
				power_q   <= POWER_RST;
				out_vld_q <= 1'b1;
			end
		end
	end

	// input byte and result payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			byte_q <= chars.char_byte;
			last_q <= chars.last_char;
		end
		if ((state_q == ST_DIV_WAIT) && div_done) begin
			result_q <= (table_size_q == '0) ? '0 : div_rem;
		end
	end

	assign chars.ready          = (state_q == ST_IDLE);
	assign cfg.ready            = 1'b1;
	assign buckets.valid        = out_vld_q;
	assign buckets.bucket_index = result_q;

endmodule

`default_nettype wire

// ===== hdl/pxsh_mul.sv =====
// 64x64 multiply, low 64 bits, built from one 32x32 multiplier in steps LL, LH, HL and SUM
// depends on pxsh_pkg
`default_nettype none

module pxsh_mul (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pxsh_pkg::HASH_W-1:0] op_a,
	input  wire logic [pxsh_pkg::HASH_W-1:0] op_b,
	output logic                           done,
	output logic [pxsh_pkg::HASH_W-1:0]    product
);
	import pxsh_pkg::*;

	localparam int HALF_W = HASH_W / 2;

	localparam logic [1:0] STEP_LL  = 2'd0;
	localparam logic [1:0] STEP_LH  = 2'd1;
	localparam logic [1:0] STEP_HL  = 2'd2;
	localparam logic [1:0] STEP_SUM = 2'd3;

	logic              busy_q;
	logic              done_q;
	logic [1:0]        step_q;
	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [HASH_W-1:0] mul_res;
	logic [HASH_W-1:0] prod_q;
	logic [HASH_W-1:0] acc_q;

	// operand halves for each partial product; the high-by-high term wraps away
	always_comb begin
		case (step_q)
			STEP_LH: begin
				mul_a = op_a[HALF_W-1:0];
				mul_b = op_b[HASH_W-1:HALF_W];
			end
			STEP_HL: begin
				mul_a = op_a[HASH_W-1:HALF_W];
				mul_b = op_b[HALF_W-1:0];
			end
			default: begin
				mul_a = op_a[HALF_W-1:0];
				mul_b = op_b[HALF_W-1:0];
			end
		endcase
	end

	assign mul_res = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_LL;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_LL;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == STEP_SUM) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product register, then accumulate one step behind
	always_ff @(posedge clk) begin
		if (busy_q) begin
			prod_q <= mul_res;
			case (step_q)
				STEP_LH: acc_q <= prod_q;
				STEP_HL, STEP_SUM: begin
					acc_q[HASH_W-1:HALF_W] <= acc_q[HASH_W-1:HALF_W] + prod_q[HALF_W-1:0];
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

// ===== hdl/pxsh_mod.sv =====
// 64-bit by 32-bit remainder, restoring, one dividend bit per cycle
// depends on pxsh_pkg
`default_nettype none

module pxsh_mod (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pxsh_pkg::HASH_W-1:0]  dividend,
	input  wire logic [pxsh_pkg::TABLE_W-1:0] divisor,
	output logic                              done,
	output logic [pxsh_pkg::TABLE_W-1:0]      remainder
);
	import pxsh_pkg::*;

	localparam int              CNT_W     = $clog2(HASH_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HASH_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [HASH_W-1:0]  num_q;
	logic [TABLE_W-1:0] den_q;
	logic [TABLE_W-1:0] rem_q;
	logic [TABLE_W:0]   trial;
	logic [TABLE_W:0]   diff;
	logic               fits;

	// shift in the next dividend bit and subtract when it fits
	assign trial = {rem_q, num_q[HASH_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and dividend shifter
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[HASH_W-2:0], 1'b0};
			rem_q <= fits ? diff[TABLE_W-1:0] : trial[TABLE_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hdl/pxsh_checker.sv =====
// port-level checks for the string hash core, attached by bind
// depends on pxsh_pkg and polynomial_xor_string_hash_core_macros.svh
`default_nettype none
`include "polynomial_xor_string_hash_core_macros.svh"

module pxsh_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [pxsh_pkg::TABLE_W-1:0] bucket_index,
	input wire logic                         cfg_valid,
	input wire logic                         cfg_ready,
	input wire logic [pxsh_pkg::TABLE_W-1:0] cfg_data
);
	import pxsh_pkg::*;

	logic [TABLE_W-1:0] ts_q;
	logic               index_ok;

	// shadow of the table size as written on the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= TABLE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			ts_q <= cfg_data;
		end
	end

	// index inside the table, zero for an empty table
	assign index_ok = (ts_q == '0) ? (bucket_index == '0) : (bucket_index < ts_q);

	// an index beat waits until taken, with a steady value
	`PXSH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`PXSH_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(bucket_index))

	// each byte keeps the core busy for the following cycle
	`PXSH_ASSERT_NXT(a_busy_after_byte, clk, arst_n, in_valid && in_ready, !in_ready)

	// the index always lies inside the table
	`PXSH_ASSERT_IMP(a_index_range, clk, arst_n, out_valid, index_ok)

endmodule

bind polynomial_xor_string_hash_core pxsh_checker u_pxsh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (chars.valid),
	.in_ready     (chars.ready),
	.out_valid    (buckets.valid),
	.out_ready    (buckets.ready),
	.bucket_index (buckets.bucket_index),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready),
	.cfg_data     (cfg.table_size)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench of the polynomial xor string hash core: byte strings in, bucket indexes out
// depends on pxsh_pkg and the channel interfaces in pxsh_ifs.sv

module testbench;
	import pxsh_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 8;
	localparam int IDLE_PCT = 35;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_ITEMS = 260;

	logic clk;
	logic arst_n;

	pxsh_char_if chars_if ();
	pxsh_bucket_if buckets_if ();
	pxsh_cfg_if cfg_if ();

	polynomial_xor_string_hash_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.buckets (buckets_if),
		.cfg     (cfg_if)
	);

	// predictor state, mirrors the block
	logic [HASH_W-1:0]  hash_acc;
	logic [HASH_W-1:0]  prime_power;
	logic [TABLE_W-1:0] bucket_count;
	logic [TABLE_W-1:0] expected_buckets[$];

	logic [TABLE_W-1:0] bucket_want;
	int                 mismatch_count;
	int                 cycle_count;
	bit                 steady_flow;
	bit                 hold_request;

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL polynomial_xor_string_hash_core");
			$finish;
		end
	end

	// fold one byte into the predicted hash, queue a bucket index on the final byte
	function automatic void hash_char(input logic [CHAR_W-1:0] ch, input logic last);
		logic [HASH_W-1:0] ch_ext;
		ch_ext = {{(HASH_W-CHAR_W){ch[CHAR_W-1]}}, ch};
		hash_acc = (hash_acc + ch_ext * prime_power) ^ HASH_MASK;
		prime_power = prime_power * HASH_PRIME;
		if (last) begin
			if (bucket_count == '0)
				expected_buckets.push_back('0);
			else
				expected_buckets.push_back(TABLE_W'(hash_acc % {32'd0, bucket_count}));
			hash_acc = HASH_RST;
			prime_power = POWER_RST;
		end
	endfunction

	// byte values with the sign boundary and zero favored
	function automatic logic [CHAR_W-1:0] pick_char();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'h80;
			2: return 8'h7f;
			3: return 8'hff;
			default: return CHAR_W'($urandom);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && buckets_if.valid && buckets_if.ready) begin
			if (expected_buckets.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected bucket index beat: got %0d", buckets_if.bucket_index);
			end else begin
				bucket_want = expected_buckets.pop_front();
				if (buckets_if.bucket_index !== bucket_want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("bucket index mismatch: expected %0d got %0d",
							bucket_want, buckets_if.bucket_index);
				end
			end
		end
	end

	// receiver: random stalls, a long hold-off on request
	initial begin
		buckets_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				buckets_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			buckets_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// send one byte beat, with a random gap in front of it
	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
		if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			chars_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_byte <= ch;
		chars_if.last_char <= last;
		do @(posedge clk); while (!chars_if.ready);
		hash_char(ch, last);
	endtask

	task automatic send_string(input int len);
		for (int i = 0; i < len; i++)
			send_char(pick_char(), i == len - 1);
	endtask

	// short strings mostly, a long one now and then
	task automatic send_random_strings(input int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			send_string(len);
			sent += len;
		end
	endtask

	// stop sending and let every result and any byte in flight finish
	task automatic drain_block();
		chars_if.valid <= 1'b0;
		while (expected_buckets.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_table_size(input logic [TABLE_W-1:0] size);
		drain_block();
		cfg_if.valid <= 1'b1;
		cfg_if.table_size <= size;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		bucket_count = size;
	endtask

	// byte extremes, zero bytes inside a string, power wrap, at the reset table size
	task automatic test_byte_extremes();
		send_char(8'h00, 1'b1);
		send_char(8'h7f, 1'b1);
		send_char(8'h80, 1'b1);
		send_char(8'hff, 1'b1);
		send_char(8'h61, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'h62, 1'b1);
		for (int i = 0; i < 12; i++)
			send_char(8'hff, i == 11);
		send_char(8'h80, 1'b0);
		send_char(8'h7f, 1'b1);
	endtask

	// table size extremes, zero included
	task automatic test_table_size_extremes();
		logic [TABLE_W-1:0] sizes[3];
		sizes = '{32'd1, 32'hffff_ffff, 32'd0};
		foreach (sizes[i]) begin
			write_table_size(sizes[i]);
			send_char(8'hff, 1'b1);
			send_char(8'h80, 1'b0);
			send_char(8'h01, 1'b1);
			send_string(4);
		end
	endtask

	// receiver held off while short strings keep coming
	task automatic test_result_backpressure();
		write_table_size(32'd1024);
		hold_request = 1'b1;
		for (int i = 0; i < 30; i++)
			send_char(pick_char(), 1'b1);
	endtask

	// random strings over several table sizes, one phase with no idling
	task automatic test_random_strings();
		logic [TABLE_W-1:0] sizes[4];
		sizes = '{TABLE_W'($urandom), TABLE_W'($urandom_range(1, 64)), 32'hffff_ffff,
			32'd1 << $urandom_range(0, 31)};
		foreach (sizes[i]) begin
			write_table_size(sizes[i]);
			steady_flow = (i == 2);
			send_random_strings(RANDOM_ITEMS);
		end
		steady_flow = 1'b0;
	endtask

	// reset and test sequence
	initial begin
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_byte = '0;
		chars_if.last_char = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.table_size = '0;
		hash_acc = HASH_RST;
		prime_power = POWER_RST;
		bucket_count = TABLE_SIZE_RST;
		mismatch_count = 0;
		cycle_count = 0;
		steady_flow = 1'b0;
		hold_request = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_byte_extremes();
		test_table_size_extremes();
		test_result_backpressure();
		test_random_strings();
		drain_block();

		if (mismatch_count == 0 && expected_buckets.size() == 0)
			$display("PASS polynomial_xor_string_hash_core");
		else
			$display("FAIL polynomial_xor_string_hash_core");
		$finish;
	end

endmodule
